/* hw/rtl/dqnco_pkg.sv */
// ----------------------------------------------------------------------------
// dqnco_pkg
// Shared constants and tables for the dual quadrature oscillator: register
// indexes, exponent roots, arctangent table and output scaling.
// ----------------------------------------------------------------------------
package dqnco_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_KNOB_A    = 2'd0;
  localparam logic [1:0] CFG_KNOB_B    = 2'd1;
  localparam logic [1:0] CFG_BASE_STEP = 2'd2;

  localparam int unsigned BASE_STEP_RST = 23409794;
  localparam int unsigned GAIN_Q30      = 652032874;
  localparam int unsigned AMP           = 10240;
  localparam logic [15:0] SLOW_Q16      = 16'd65208;
  localparam int unsigned ROOT_COUNT    = 11;
  localparam int unsigned ATAN_DEPTH    = 24;

  // Integer square root, used only to build the root table
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q30 roots 2^(2^-k): entry 0 is 2^31, each next is the root of the last
  function automatic logic [11:0][31:0] root_table();
    logic [11:0][31:0] t;
    logic [63:0]       r;
    t[0] = 32'h8000_0000;
    for (int k = 1; k < 12; k++) begin
      r    = isqrt64({t[k-1], 30'd0} & 64'h3FFF_FFFF_FFFF_FFFF | (64'(t[k-1]) << 30));
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam logic [11:0][31:0] ROOT_TAB = root_table();

  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

/* hw/rtl/dqnco_fifo.sv */
// ----------------------------------------------------------------------------
// dqnco_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module dqnco_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r;
  logic         rptr_r;
  logic [1:0]   cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rptr_r];

  // Write payload
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

/* hw/rtl/dqnco_front.sv */
// ----------------------------------------------------------------------------
// dqnco_front
// Input side: takes a transaction, forms both pitches and converts both phase
// inputs to phase offsets with a reciprocal multiply by one fifth.
// ----------------------------------------------------------------------------
module dqnco_front #(
  parameter int PB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_pitch_cv_a,
  input  logic signed [15:0]   in_phase_cv_a,
  input  logic signed [15:0]   in_pitch_cv_b,
  input  logic signed [15:0]   in_phase_cv_b,
  input  logic signed [14:0]   knob_a,
  input  logic signed [14:0]   knob_b,
  output logic                 q_push,
  output logic [2*17+2*(PB+1)-1:0] q_data,
  input  logic                 q_full
);
  import dqnco_pkg::*;

  localparam int S = PB - 12;
  // Fraction of (r << S) + 2 over five for each remainder r of |cv| / 5
  localparam logic [63:0] TAIL [5] = '{
    64'd0,
    ((64'd1 << S) + 64'd2) / 64'd5,
    ((64'd2 << S) + 64'd2) / 64'd5,
    ((64'd3 << S) + 64'd2) / 64'd5,
    ((64'd4 << S) + 64'd2) / 64'd5
  };

  typedef enum logic {F_IDLE, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic signed [16:0] pa_r, pb_r;
  logic               neg_a_r, neg_b_r;
  logic [PB-1:0]      off_a_r, off_b_r;

  logic [15:0]   mag_a, mag_b;
  logic [31:0]   qa_prod, qb_prod;
  logic [13:0]   qa, qb;
  logic [2:0]    ra, rb;
  logic [PB-1:0] off_a, off_b;
  logic          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = {pa_r, pb_r, neg_a_r, off_a_r, neg_b_r, off_b_r};

  // Magnitudes of the phase inputs
  assign mag_a = in_phase_cv_a[15] ? 16'(-in_phase_cv_a) : 16'(in_phase_cv_a);
  assign mag_b = in_phase_cv_b[15] ? 16'(-in_phase_cv_b) : 16'(in_phase_cv_b);

  // Quotient and remainder of |cv| / 5, exact for 16-bit magnitudes
  assign qa_prod = 32'(mag_a) * 32'd52429;
  assign qb_prod = 32'(mag_b) * 32'd52429;
  assign qa      = qa_prod[31:18];
  assign qb      = qb_prod[31:18];
  assign ra      = 3'(mag_a - 16'(qa) * 16'd5);
  assign rb      = 3'(mag_b - 16'(qb) * 16'd5);

  // Offset is (|cv| * 2^PB + 10240) / 20480 = ((|cv| << (PB-12)) + 2) / 5
  assign off_a = PB'({qa, {S{1'b0}}}) + PB'(TAIL[ra]);
  assign off_b = PB'({qb, {S{1'b0}}}) + PB'(TAIL[rb]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            pa_r    <= 17'(knob_a) + 17'(in_pitch_cv_a);
            pb_r    <= 17'(knob_b) + 17'(in_pitch_cv_b);
            neg_a_r <= in_phase_cv_a[15];
            neg_b_r <= in_phase_cv_b[15];
            off_a_r <= off_a;
            off_b_r <= off_b;
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/dqnco_cordic.sv */
// ----------------------------------------------------------------------------
// dqnco_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then quadrant
// fold, rounding and clamping to the 5 V output range.
// ----------------------------------------------------------------------------
module dqnco_cordic #(
  parameter int SB = 16,
  parameter int CS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [14:0] sine,
  output logic signed [14:0] cosine
);
  import dqnco_pkg::*;

  localparam int XW  = SB + 16;
  localparam int NST = (CS < 24) ? CS : 24;
  localparam logic [63:0] X0_FULL =
    (64'(GAIN_Q30) * 64'(AMP) + (64'd1 << (29 - SB))) >> (30 - SB);
  localparam logic signed [XW-1:0] X0 = XW'(X0_FULL);
  localparam logic signed [XW:0]   AMP_S = (XW+1)'(AMP);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t            state_r;
  logic [4:0]         i_r;
  logic [1:0]         q_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [32:0] z_r;

  logic signed [XW-1:0] xs, ys, cv, sv;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  // Fold the quadrant back
  always_comb begin
    unique case (q_r)
      2'd0:    begin cv = x_r;  sv = y_r;  end
      2'd1:    begin cv = -y_r; sv = x_r;  end
      2'd2:    begin cv = -x_r; sv = -y_r; end
      default: begin cv = y_r;  sv = -x_r; end
    endcase
  end

  function automatic logic signed [14:0] round_clamp(input logic signed [XW-1:0] v);
    logic signed [XW:0] s;
    logic signed [XW:0] r;
    s = {v[XW-1], v} + ((XW+1)'(1) << (SB - 1));
    r = s >>> SB;
    if (r > AMP_S)        return 15'(AMP_S);
    else if (r < -AMP_S)  return 15'(-AMP_S);
    else                  return r[14:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
      i_r     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r     <= X0;
            y_r     <= '0;
            z_r     <= {3'b000, angle[29:0]};
            q_r     <= angle[31:30];
            i_r     <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          // Rotate toward zero residual angle
          if (!z_r[32]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - 33'(ATAN_TAB[i_r]);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + 33'(ATAN_TAB[i_r]);
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(NST - 1)) state_r <= C_FIN;
        end
        C_FIN: begin
          sine    <= round_clamp(sv);
          cosine  <= round_clamp(cv);
          done    <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/dqnco_back.sv */
// ----------------------------------------------------------------------------
// dqnco_back
// Execution side: exponential increments, phase accumulation with sync,
// sine/cosine through a shared CORDIC, and the result register.
// ----------------------------------------------------------------------------
module dqnco_back #(
  parameter int PB = 32,
  parameter int SB = 16,
  parameter int CS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [2*17+2*(PB+1)-1:0] q_data,
  output logic               q_pop,
  input  logic [30:0]        base_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_sine_a,
  output logic signed [14:0] out_cosine_a,
  output logic signed [14:0] out_sine_b,
  output logic signed [14:0] out_cosine_b
);
  import dqnco_pkg::*;

  localparam logic [62:0]    PHALF63 = 63'd1 << (PB - 1);
  localparam logic [PB-1:0]  PHALF   = PB'(1) << (PB - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_EXP, B_MUL, B_SHIFT, B_UPD, B_SYNC, B_DIFF, B_SNAP, B_THETA, B_ROT, B_OUT
  } bstate_t;

  bstate_t             state_r;
  logic                sel_r;
  logic [3:0]          k_r;
  logic [31:0]         m_r;
  logic [62:0]         prod_r;
  logic [PB-1:0]       inc_a_r, inc_b_r, acc_a_r, acc_b_r, slow_r, d_r;
  logic signed [16:0]  pa_r, pb_r;
  logic                neg_a_r, neg_b_r, eq_r;
  logic [PB-1:0]       off_a_r, off_b_r;
  logic signed [14:0]  sa_r, ca_r, sb_r, cb_r;

  logic signed [16:0]  pitch;
  logic [10:0]         frac;
  logic [63:0]         mprod;
  logic [63:0]         mround;
  logic signed [7:0]   sh;
  logic [62:0]         raw;
  logic [PB-1:0]       inc;
  logic [PB+15:0]      slow_full;
  logic [PB-1:0]       gap, acc, off, theta;
  logic                neg;
  logic [31:0]         angle;
  logic                cd_start, cd_done;
  logic signed [14:0]  cd_sin, cd_cos;

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign pitch = sel_r ? pb_r : pa_r;
  assign frac  = pitch[10:0];

  // Multiply by the next root, rounded half up
  assign mprod  = 64'(m_r) * 64'(ROOT_TAB[k_r]);
  assign mround = (mprod + (64'd1 << 29)) >> 30;

  // Shift the product by 30 - octave and saturate at half a cycle
  assign sh = 8'sd30 - 8'(signed'(pitch[16:11]));
  always_comb begin
    if (sh <= 8'sd0) raw = (prod_r != '0) ? PHALF63 : '0;
    else             raw = prod_r >> sh[5:0];
    inc = (raw > PHALF63) ? PHALF : raw[PB-1:0];
  end

  assign slow_full = (PB+16)'(inc_b_r) * (PB+16)'(SLOW_Q16);
  assign gap       = (d_r > PHALF) ? PB'(-d_r) : d_r;

  // Phase plus offset for the selected oscillator
  assign acc   = sel_r ? acc_b_r : acc_a_r;
  assign off   = sel_r ? off_b_r : off_a_r;
  assign neg   = sel_r ? neg_b_r : neg_a_r;
  assign theta = neg ? acc - off : acc + off;

  generate
    if (PB >= 32) begin : g_trunc
      assign angle = theta[PB-1 -: 32];
    end else begin : g_fill
      assign angle = {theta, {(32-PB){1'b0}}};
    end
  endgenerate

  assign cd_start = (state_r == B_THETA);

  dqnco_cordic #(.SB(SB), .CS(CS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cd_start),
    .angle  (angle),
    .done   (cd_done),
    .sine   (cd_sin),
    .cosine (cd_cos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_valid <= 1'b0;
      acc_a_r   <= '0;
      acc_b_r   <= '0;
      sel_r     <= 1'b0;
      k_r       <= '0;
    end else begin
      // Raise valid on publish, drop it once the transaction is taken
      if (state_r == B_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                   out_valid <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            {pa_r, pb_r, neg_a_r, off_a_r, neg_b_r, off_b_r} <= q_data;
            sel_r   <= 1'b0;
            k_r     <= 4'd1;
            m_r     <= 32'h4000_0000;
            state_r <= B_EXP;
          end
        end
        B_EXP: begin
          // Fold in one root per fraction bit
          if (frac[4'(ROOT_COUNT) - k_r]) m_r <= mround[31:0];
          k_r <= k_r + 4'd1;
          if (k_r == 4'(ROOT_COUNT)) state_r <= B_MUL;
        end
        B_MUL: begin
          prod_r  <= 63'(base_step) * 63'(m_r);
          state_r <= B_SHIFT;
        end
        B_SHIFT: begin
          if (!sel_r) begin
            inc_a_r <= inc;
            sel_r   <= 1'b1;
            k_r     <= 4'd1;
            m_r     <= 32'h4000_0000;
            state_r <= B_EXP;
          end else begin
            inc_b_r <= inc;
            state_r <= B_UPD;
          end
        end
        B_UPD: begin
          acc_a_r <= acc_a_r + inc_a_r;
          slow_r  <= slow_full[PB+15:16];
          eq_r    <= (pa_r == pb_r);
          state_r <= B_SYNC;
        end
        B_SYNC: begin
          // Slow B down while pitches match and phases differ
          if (eq_r && (acc_a_r != acc_b_r)) begin
            acc_b_r <= acc_b_r + slow_r;
            state_r <= B_DIFF;
          end else begin
            acc_b_r <= acc_b_r + inc_b_r;
            sel_r   <= 1'b0;
            state_r <= B_THETA;
          end
        end
        B_DIFF: begin
          d_r     <= acc_b_r - acc_a_r;
          state_r <= B_SNAP;
        end
        B_SNAP: begin
          // Snap onto A once within one increment
          if (gap <= inc_b_r) acc_b_r <= acc_a_r;
          sel_r   <= 1'b0;
          state_r <= B_THETA;
        end
        B_THETA: begin
          state_r <= B_ROT;
        end
        B_ROT: begin
          if (cd_done) begin
            if (!sel_r) begin
              sa_r    <= cd_sin;
              ca_r    <= cd_cos;
              sel_r   <= 1'b1;
              state_r <= B_THETA;
            end else begin
              sb_r    <= cd_sin;
              cb_r    <= cd_cos;
              state_r <= B_OUT;
            end
          end
        end
        B_OUT: begin
          // Publish once the result register is free
          if (!out_valid || !out_stall) begin
            out_sine_a   <= sa_r;
            out_cosine_a <= ca_r;
            out_sine_b   <= sb_r;
            out_cosine_b <= cb_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/dual_quadrature_nco_phase_sync_unit.sv */
// ----------------------------------------------------------------------------
// dual_quadrature_nco_phase_sync_unit
// Two exponential-pitch quadrature oscillators with phase sync.
// ----------------------------------------------------------------------------
// Each transaction is one sample tick and yields one result transaction with
// sine and cosine of both oscillators. The front end registers a sample,
// converting the phase inputs on the way in, and hands it to the queue once
// the queue is not full. The back end takes it from the queue, runs two
// increment passes (11 exponent steps on one multiplier, the base multiply
// and the shift), updates both phases, adds a difference step and a snap
// step when the pitches match and B is pulled toward A, makes two passes
// through the single iterative CORDIC with N = CORDIC_STEPS capped at 24,
// and publishes the result, which may wait on out_stall. A two-entry queue
// between the ends lets the next samples be taken while the current one is
// computed.
module dual_quadrature_nco_phase_sync_unit #(
  parameter int PHASE_BITS   = 32,
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pitch_cv_a,
  input  logic signed [15:0] in_phase_cv_a,
  input  logic signed [15:0] in_pitch_cv_b,
  input  logic signed [15:0] in_phase_cv_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_sine_a,
  output logic signed [14:0] out_cosine_a,
  output logic signed [14:0] out_sine_b,
  output logic signed [14:0] out_cosine_b
);
  import dqnco_pkg::*;

  localparam int QW = 2*17 + 2*(PHASE_BITS+1);

  logic signed [14:0] knob_a_r, knob_b_r;
  logic [30:0]        base_step_r;
  logic               q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]      q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_a_r    <= '0;
      knob_b_r    <= '0;
      base_step_r <= 31'(BASE_STEP_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KNOB_A:    knob_a_r    <= cfg_wdata[14:0];
        CFG_KNOB_B:    knob_b_r    <= cfg_wdata[14:0];
        CFG_BASE_STEP: base_step_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  dqnco_front #(.PB(PHASE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pitch_cv_a (in_pitch_cv_a),
    .in_phase_cv_a (in_phase_cv_a),
    .in_pitch_cv_b (in_pitch_cv_b),
    .in_phase_cv_b (in_phase_cv_b),
    .knob_a        (knob_a_r),
    .knob_b        (knob_b_r),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  dqnco_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  dqnco_back #(.PB(PHASE_BITS), .SB(SAMPLE_BITS), .CS(CORDIC_STEPS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .base_step    (base_step_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sine_a   (out_sine_a),
    .out_cosine_a (out_cosine_a),
    .out_sine_b   (out_sine_b),
    .out_cosine_b (out_cosine_b)
  );

  // Queue never overflows or underflows
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("queue pop while empty");
  // A new result never overwrites one still waiting (checked on out_sine_b)
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_sine_b))
    else $error("result overwritten while stalled");

endmodule
